// File: rtl/mcbcd_pkg.sv
// ----------------------------------------------------------------------------
// mcbcd_pkg
// Types and codes shared by the block-chain directory and its checker.
// ----------------------------------------------------------------------------
package mcbcd_pkg;

  localparam logic [2:0] ACT_CREATE   = 3'd0;
  localparam logic [2:0] ACT_DELETE   = 3'd1;
  localparam logic [2:0] ACT_LOCATE   = 3'd2;
  localparam logic [2:0] ACT_FORMAT   = 3'd3;
  localparam logic [2:0] ACT_UNFORMAT = 3'd4;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_NOT_FMT = 3'd1;
  localparam logic [2:0] STS_NO_FILE = 3'd2;
  localparam logic [2:0] STS_EXISTS  = 3'd3;
  localparam logic [2:0] STS_FULL    = 3'd4;

  localparam logic [7:0]  BLK_FREE  = 8'hA0;
  localparam logic [7:0]  BLK_FIRST = 8'h51;
  localparam logic [7:0]  BLK_MID   = 8'h52;
  localparam logic [7:0]  BLK_LAST  = 8'h53;
  localparam logic [7:0]  HI_MASK   = 8'hF0;
  localparam logic [7:0]  HI_USED   = 8'h50;
  localparam logic [7:0]  LO_MASK   = 8'h0F;
  localparam logic [15:0] END_LINK  = 16'hFFFF;
  localparam logic [3:0]  MAX_SEGS  = 4'd15;
  localparam int unsigned NAME_BYTES = 20;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] name_lo;
    logic [63:0] name_mid;
    logic [31:0] name_hi;
    logic [3:0]  block_count;
    logic [16:0] byte_offset;
    logic [16:0] span_bytes;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] card_address;
    logic [13:0] segment_bytes;
    logic [3:0]  first_block;
    logic        formatted;
    logic        last;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_SRCH, S_CNT, S_ALLOC, S_DEL, S_LCHK, S_LSEG, S_FMT, S_OUT
  } st_e;

endpackage

// File: rtl/memory_card_block_chain_directory.sv
// ----------------------------------------------------------------------------
// memory_card_block_chain_directory
// Block-chain directory: create, delete, locate span, format, unformat.
// ----------------------------------------------------------------------------
// Operation: search visits one entry per cycle through a single entry port;
//   create adds a free scan and an allocate pass, delete/locate add a chain
//   walk of up to N blocks (locate checks each block, then emits each segment
//   result and holds it until it is taken).
// Throughput: one item at a time; ready only when the last result is taken.
// Reset: async, all entries free, links end of chain, card formatted.
module memory_card_block_chain_directory
  import mcbcd_pkg::*;
#(
  parameter int NUM_BLOCKS  = 15,
  parameter int BLOCK_BYTES = 8192,
  parameter int NAME_CHARS  = 20
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int LW = $clog2((NUM_BLOCKS + 2) * BLOCK_BYTES + 262144);
  localparam int BW = $clog2(BLOCK_BYTES + 1);
  localparam int NW = 8 * NAME_BYTES;

  logic [7:0]    est_q [NUM_BLOCKS];
  logic [15:0]   elink_q [NUM_BLOCKS];
  logic [NW-1:0] ename_q [NUM_BLOCKS];

  st_e st_q, st_d;
  logic [2:0]    act_q, act_d;
  logic [NW-1:0] name_q, name_d;
  logic [3:0]    want_q, want_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] fidx_q, fidx_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [15:0]   prev_q, prev_d;
  logic [CW-1:0] steps_q, steps_d;
  logic          walk_q, walk_d;
  logic [LW-1:0] pos_q, pos_d, ofs_q, ofs_d, rem_q, rem_d;
  logic [3:0]    seg_q, seg_d;
  logic [BW-1:0] start_q, start_d;
  logic          cont_q, cont_d;
  logic          fmt_q, fmt_d;
  logic          ov_q, ov_d;
  out_t          out_q, out_d;

  logic          wr_en, wr_link_en, wr_name_en;
  logic [7:0]    wr_st;
  logic [15:0]   wr_link;
  logic [NW-1:0] wr_name;

  logic [NW-1:0] raw, norm;
  logic          ended;
  logic [7:0]    nbyte;

  logic [7:0]    cur_st;
  logic [15:0]   cur_link;
  logic          is_free, is_match, link_ok, last_idx, hit, loc_go, del_more;
  logic [LW-1:0] n_full, n_seg, addr;
  logic [IW:0]   idx_p1, fidx_p1;

  assign raw = {in_i.name_hi, in_i.name_mid, in_i.name_lo};

  always_comb begin
    ended = 1'b0;
    norm  = '0;
    nbyte = '0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      nbyte = raw[8*k +: 8];
      if (k >= NAME_CHARS || ended) begin
        nbyte = 8'h00;
      end
      if (nbyte == 8'h00) begin
        ended = 1'b1;
      end
      norm[8*k +: 8] = nbyte;
    end
  end

  assign cur_st   = est_q[idx_q];
  assign cur_link = elink_q[idx_q];
  assign is_free  = (cur_st & HI_MASK) != HI_USED;
  assign is_match = (cur_st == BLK_FIRST) && (ename_q[idx_q] == name_q);
  assign link_ok  = (cur_link != END_LINK) && (cur_link < 16'(NUM_BLOCKS));
  assign last_idx = idx_q == IW'(NUM_BLOCKS - 1);
  assign hit      = ofs_q < pos_q + LW'(BLOCK_BYTES);
  assign loc_go   = walk_q && (rem_q != '0) && (steps_q < CW'(NUM_BLOCKS));
  assign del_more = link_ok && ((steps_q + 1'b1) < CW'(NUM_BLOCKS));
  assign n_full   = LW'(BLOCK_BYTES) - LW'(start_q);
  assign n_seg    = (rem_q < n_full) ? rem_q : n_full;
  assign idx_p1   = {1'b0, idx_q} + 1'b1;
  assign fidx_p1  = {1'b0, fidx_q} + 1'b1;
  assign addr     = LW'(LW'(idx_p1) * LW'(BLOCK_BYTES)) + LW'(start_q);

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_valid_i) st_d = S_DISP;
      S_DISP: begin
        case (act_q)
          ACT_CREATE:               st_d = (!fmt_q || want_q == '0) ? S_OUT : S_SRCH;
          ACT_DELETE, ACT_LOCATE:   st_d = S_SRCH;
          ACT_FORMAT:               st_d = S_FMT;
          default:                  st_d = S_OUT;
        endcase
      end
      S_SRCH: begin
        if (is_match) begin
          case (act_q)
            ACT_DELETE: st_d = S_DEL;
            ACT_LOCATE: st_d = S_LCHK;
            default:    st_d = S_OUT;
          endcase
        end else if (last_idx) begin
          st_d = (act_q == ACT_CREATE) ? S_CNT : S_OUT;
        end
      end
      S_CNT: begin
        if (is_free && (cnt_q + 1'b1) == want_q) begin
          st_d = S_ALLOC;
        end else if (last_idx) begin
          st_d = S_OUT;
        end
      end
      S_ALLOC: if (is_free && cnt_q == '0) st_d = S_OUT;
      S_DEL:   if (!del_more) st_d = S_OUT;
      S_LCHK: begin
        if (!loc_go || (hit && seg_q == MAX_SEGS)) begin
          st_d = S_OUT;
        end else if (hit) begin
          st_d = S_LSEG;
        end
      end
      S_LSEG:  st_d = S_OUT;
      S_FMT:   if (last_idx) st_d = S_OUT;
      S_OUT:   if (out_ready_i) st_d = cont_q ? S_LCHK : S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    act_d = act_q;  name_d = name_q;  want_d = want_q;  idx_d = idx_q;
    fidx_d = fidx_q;  cnt_d = cnt_q;  prev_d = prev_q;  steps_d = steps_q;
    walk_d = walk_q;  pos_d = pos_q;  ofs_d = ofs_q;  rem_d = rem_q;
    seg_d = seg_q;  start_d = start_q;  cont_d = cont_q;  fmt_d = fmt_q;
    ov_d = ov_q;  out_d = out_q;
    wr_en = 1'b0;  wr_link_en = 1'b0;  wr_name_en = 1'b0;
    wr_st = cur_st;  wr_link = cur_link;  wr_name = '0;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = in_i.action;
          name_d  = norm;
          want_d  = in_i.block_count;
          ofs_d   = LW'(in_i.byte_offset);
          rem_d   = LW'(in_i.span_bytes);
          pos_d   = '0;
          seg_d   = '0;
          steps_d = '0;
          cnt_d   = '0;
          idx_d   = '0;
          cont_d  = 1'b0;
          out_d   = '0;
        end
      end
      S_DISP: begin
        out_d.last = 1'b1;
        ov_d = 1'b1;
        case (act_q)
          ACT_CREATE: begin
            if (!fmt_q) begin
              out_d.status = STS_NOT_FMT;
            end else if (want_q == '0) begin
              out_d.status = STS_NO_FILE;
            end else begin
              ov_d = 1'b0;
            end
          end
          ACT_DELETE, ACT_LOCATE, ACT_FORMAT: ov_d = 1'b0;
          ACT_UNFORMAT: fmt_d = 1'b0;
          default: ;
        endcase
      end
      S_SRCH: begin
        if (is_match) begin
          fidx_d = idx_q;
          walk_d = 1'b1;
          if (act_q == ACT_CREATE) begin
            out_d.status = STS_EXISTS;
            out_d.last   = 1'b1;
            ov_d         = 1'b1;
          end
        end else if (last_idx) begin
          idx_d = '0;
          if (act_q != ACT_CREATE) begin
            out_d.status = STS_NO_FILE;
            out_d.last   = 1'b1;
            ov_d         = 1'b1;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_CNT: begin
        if (is_free && (cnt_q + 1'b1) == want_q) begin
          cnt_d  = want_q - 1'b1;
          prev_d = END_LINK;
        end else begin
          if (is_free) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (last_idx) begin
            out_d.status = STS_FULL;
            out_d.last   = 1'b1;
            ov_d         = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_ALLOC: begin
        if (is_free) begin
          wr_en      = 1'b1;
          wr_link_en = 1'b1;
          wr_name_en = 1'b1;
          wr_link    = prev_q;
          wr_st      = (cnt_q == '0) ? BLK_FIRST :
                       (cnt_q == want_q - 1'b1) ? BLK_LAST : BLK_MID;
          wr_name    = (cnt_q == '0) ? name_q : '0;
          prev_d     = 16'(idx_q);
          if (cnt_q == '0) begin
            out_d.status      = STS_OK;
            out_d.first_block = 4'(idx_p1);
            out_d.last        = 1'b1;
            ov_d              = 1'b1;
          end else begin
            cnt_d = cnt_q - 1'b1;
            idx_d = idx_q - 1'b1;
          end
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      S_DEL: begin
        wr_en   = 1'b1;
        wr_st   = (cur_st & LO_MASK) | BLK_FREE;
        steps_d = steps_q + 1'b1;
        if (del_more) begin
          idx_d = cur_link[IW-1:0];
        end else begin
          out_d.status      = STS_OK;
          out_d.first_block = 4'(fidx_p1);
          out_d.last        = 1'b1;
          ov_d              = 1'b1;
        end
      end
      S_LCHK: begin
        if (!loc_go || (hit && seg_q == MAX_SEGS)) begin
          out_d.status        = (rem_q != '0) ? STS_NO_FILE : STS_OK;
          out_d.card_address  = '0;
          out_d.segment_bytes = '0;
          out_d.first_block   = 4'(fidx_p1);
          out_d.last          = 1'b1;
          ov_d                = 1'b1;
          cont_d              = 1'b0;
        end else if (hit) begin
          start_d = (ofs_q > pos_q) ? BW'(ofs_q - pos_q) : '0;
        end else begin
          pos_d   = pos_q + LW'(BLOCK_BYTES);
          steps_d = steps_q + 1'b1;
          if (link_ok) begin
            idx_d = cur_link[IW-1:0];
          end else begin
            walk_d = 1'b0;
          end
        end
      end
      S_LSEG: begin
        out_d.status        = STS_OK;
        out_d.card_address  = 17'(addr);
        out_d.segment_bytes = 14'(n_seg);
        out_d.first_block   = 4'(fidx_p1);
        out_d.last          = 1'b0;
        ov_d                = 1'b1;
        cont_d              = 1'b1;
        ofs_d               = ofs_q + n_seg;
        rem_d               = rem_q - n_seg;
        seg_d               = seg_q + 1'b1;
        pos_d               = pos_q + LW'(BLOCK_BYTES);
        steps_d             = steps_q + 1'b1;
        if (link_ok) begin
          idx_d = cur_link[IW-1:0];
        end else begin
          walk_d = 1'b0;
        end
      end
      S_FMT: begin
        wr_en      = 1'b1;
        wr_link_en = 1'b1;
        wr_name_en = 1'b1;
        wr_st      = BLK_FREE;
        wr_link    = END_LINK;
        wr_name    = '0;
        if (last_idx) begin
          fmt_d        = 1'b1;
          out_d.status = STS_OK;
          out_d.last   = 1'b1;
          ov_d         = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_OUT: if (out_ready_i) ov_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      fmt_q   <= 1'b1;
      ov_q    <= 1'b0;
      cont_q  <= 1'b0;
      walk_q  <= 1'b0;
      idx_q   <= '0;
      cnt_q   <= '0;
      steps_q <= '0;
      seg_q   <= '0;
    end else begin
      st_q    <= st_d;
      fmt_q   <= fmt_d;
      ov_q    <= ov_d;
      cont_q  <= cont_d;
      walk_q  <= walk_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      steps_q <= steps_d;
      seg_q   <= seg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    name_q  <= name_d;
    want_q  <= want_d;
    fidx_q  <= fidx_d;
    prev_q  <= prev_d;
    pos_q   <= pos_d;
    ofs_q   <= ofs_d;
    rem_q   <= rem_d;
    start_q <= start_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        est_q[i]   <= BLK_FREE;
        elink_q[i] <= END_LINK;
        ename_q[i] <= '0;
      end
    end else if (wr_en) begin
      est_q[idx_q] <= wr_st;
      if (wr_link_en) begin
        elink_q[idx_q] <= wr_link;
      end
      if (wr_name_en) begin
        ename_q[idx_q] <= wr_name;
      end
    end
  end

  assign in_ready_o  = st_q == S_IDLE;
  assign out_valid_o = ov_q;

  always_comb begin
    out_o           = out_q;
    out_o.formatted = fmt_q;
  end

endmodule

// File: rtl/mcbcd_chk.sv
// ----------------------------------------------------------------------------
// mcbcd_chk
// Port-level checks for the block-chain directory, bound to the top level.
// ----------------------------------------------------------------------------
module mcbcd_chk
  import mcbcd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result item changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("block not busy after taking an item");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("ready while a result is pending");

  a_seg_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.last |-> out_o.status == STS_OK && out_o.first_block != '0)
    else $error("bad locate segment");

endmodule

bind memory_card_block_chain_directory mcbcd_chk u_mcbcd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
